// ----- design/tcnt_pkg.sv -----
package tcnt_pkg;

  // widths fixed by the port fields
  localparam int ID_W       = 13;
  localparam int TRI_W      = 20;
  localparam int EDGE_OUT_W = 14;

  // saturation value of the triangle count
  localparam logic [TRI_W-1:0] TRI_MAX = {TRI_W{1'b1}};

  // node count after reset
  localparam logic [ID_W-1:0] NODE_COUNT_RESET = 13'd4096;

endpackage

// ----- design/tcnt_ram.sv -----
module tcnt_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/tcnt_ram2r.sv -----
module tcnt_ram2r #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd0_addr,
  output logic [W-1:0]  rd0_data,
  input  logic [AW-1:0] rd1_addr,
  output logic [W-1:0]  rd1_data
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rd0_data_r;
  logic [W-1:0] rd1_data_r;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0_data_r <= mem[rd0_addr];
    rd1_data_r <= mem[rd1_addr];
  end

  assign rd0_data = rd0_data_r;
  assign rd1_data = rd1_data_r;

endmodule

// ----- design/triangle_count_oriented_unit.sv -----
// Loading: a valid edge passes S_INC_A and S_INC_B (degree read-modify-write of both ends
// on the degree memory), a dropped edge is handled in S_IDLE.
// Counting: each stored edge is oriented through S_O_EDGE, S_O_DEG, S_O_HEAD and S_O_LINK,
// then each vertex up to MAX_NODES runs the mark and two-hop walks on the list memory.
// Reset is synchronous; a clearing pass over all MAX_NODES+1 entries runs after reset and
// after each result, and no edge is taken during it. Throughput is one graph at a time.
module triangle_count_oriented_unit
  import tcnt_pkg::*;
#(
  parameter int MAX_NODES = 4096,
  parameter int MAX_EDGES = 8192
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ID_W-1:0]       in_end_a,
  input  logic [ID_W-1:0]       in_end_b,
  input  logic                  in_last_edge,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TRI_W-1:0]      out_triangle_count,
  output logic [EDGE_OUT_W-1:0] out_edges_loaded,
  output logic                  out_overflow,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ID_W-1:0]       cfg_node_count
);

  localparam int NAW = $clog2(MAX_NODES + 1);
  localparam int EAW = $clog2(MAX_EDGES + 1);
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int DW  = $clog2(2 * MAX_EDGES + 1);
  localparam int CW  = (NAW > ID_W) ? NAW : ID_W;
  localparam int LW  = NAW + EAW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_INC_A, S_INC_B, S_O_EDGE, S_O_DEG, S_O_HEAD, S_O_LINK,
    S_U_HEAD, S_U_FIRST, S_M_WALK, S_P_LIST, S_Q_HEAD, S_Q_LIST, S_Q_MARK, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [ID_W-1:0]       node_count_r, node_count_nxt;
  logic [EAW-1:0]        cnt_r, cnt_nxt;
  logic                  drop_r, drop_nxt;
  logic [TRI_W-1:0]      tri_r, tri_nxt;
  logic [NAW-1:0]        clr_r, clr_nxt;
  logic                  last_r, last_nxt;
  logic [NAW-1:0]        a_r, a_nxt, b_r, b_nxt;
  logic [DW-1:0]         inc_r, inc_nxt;
  logic [EAW-1:0]        k_r, k_nxt;
  logic [NAW-1:0]        ea_r, ea_nxt, eb_r, eb_nxt;
  logic [NAW-1:0]        src_r, src_nxt, dst_r, dst_nxt;
  logic [NAW-1:0]        u_r, u_nxt;
  logic [EAW-1:0]        hu_r, hu_nxt, p_r, p_nxt, q_r, q_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [TRI_W-1:0]      out_tri_r, out_tri_nxt;
  logic [EDGE_OUT_W-1:0] out_edges_r, out_edges_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // memory ports
  logic           deg_we;
  logic [NAW-1:0] deg_wa, deg_ra0, deg_ra1;
  logic [DW-1:0]  deg_wd, deg_rd0, deg_rd1;
  logic           edge_we;
  logic [EIW-1:0] edge_wa, edge_ra;
  logic [2*NAW-1:0] edge_wd, edge_rd;
  logic           head_we;
  logic [NAW-1:0] head_wa, head_ra;
  logic [EAW-1:0] head_wd, head_rd;
  logic           list_we;
  logic [EAW-1:0] list_wa, list_ra;
  logic [LW-1:0]  list_wd, list_rd;
  logic           mark_we;
  logic [NAW-1:0] mark_wa, mark_ra;
  logic [NAW-1:0] mark_wd, mark_rd;

  // input id check
  logic [CW-1:0]  a_c, b_c, lim_c, nc_c;
  logic           edge_ok;
  logic [NAW-1:0] a_n, b_n;

  assign a_c   = CW'(in_end_a);
  assign b_c   = CW'(in_end_b);
  assign nc_c  = CW'(node_count_r);
  assign lim_c = (nc_c > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_c;
  assign edge_ok = (a_c != '0) && (b_c != '0) && (a_c <= lim_c) && (b_c <= lim_c) &&
                   (cnt_r < EAW'(MAX_EDGES));
  assign a_n = NAW'(a_c);
  assign b_n = NAW'(b_c);

  tcnt_ram2r #(.W(DW), .D(MAX_NODES + 1)) u_deg (
    .clk(clk), .wr_en(deg_we), .wr_addr(deg_wa), .wr_data(deg_wd),
    .rd0_addr(deg_ra0), .rd0_data(deg_rd0), .rd1_addr(deg_ra1), .rd1_data(deg_rd1)
  );

  tcnt_ram #(.W(2 * NAW), .D(MAX_EDGES)) u_edge (
    .clk(clk), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
    .rd_addr(edge_ra), .rd_data(edge_rd)
  );

  tcnt_ram #(.W(EAW), .D(MAX_NODES + 1)) u_head (
    .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
    .rd_addr(head_ra), .rd_data(head_rd)
  );

  tcnt_ram #(.W(LW), .D(MAX_EDGES + 1)) u_list (
    .clk(clk), .wr_en(list_we), .wr_addr(list_wa), .wr_data(list_wd),
    .rd_addr(list_ra), .rd_data(list_rd)
  );

  tcnt_ram #(.W(NAW), .D(MAX_NODES + 1)) u_mark (
    .clk(clk), .wr_en(mark_we), .wr_addr(mark_wa), .wr_data(mark_wd),
    .rd_addr(mark_ra), .rd_data(mark_rd)
  );

  // sequencer
  always_comb begin
    logic           adv_p;
    logic           adv_u;
    logic [DW-1:0]  b_deg;
    logic [EAW-1:0] slot;

    adv_p = 1'b0;
    adv_u = 1'b0;
    b_deg = '0;
    slot  = k_r + EAW'(1);

    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    cnt_nxt        = cnt_r;
    drop_nxt       = drop_r;
    tri_nxt        = tri_r;
    clr_nxt        = clr_r;
    last_nxt       = last_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    inc_nxt        = inc_r;
    k_nxt          = k_r;
    ea_nxt         = ea_r;
    eb_nxt         = eb_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    u_nxt          = u_r;
    hu_nxt         = hu_r;
    p_nxt          = p_r;
    q_nxt          = q_r;
    out_valid_nxt  = out_valid_r;
    out_tri_nxt    = out_tri_r;
    out_edges_nxt  = out_edges_r;
    out_ovf_nxt    = out_ovf_r;

    deg_we  = 1'b0; deg_wa  = '0; deg_wd  = '0; deg_ra0 = '0; deg_ra1 = '0;
    edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = '0;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    list_we = 1'b0; list_wa = '0; list_wd = '0; list_ra = '0;
    mark_we = 1'b0; mark_wa = '0; mark_wd = '0; mark_ra = '0;

    // configuration write
    if (cfg_valid) begin
      node_count_nxt = cfg_node_count;
    end

    // result request taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        deg_we  = 1'b1;
        deg_wa  = clr_r;
        head_we = 1'b1;
        head_wa = clr_r;
        mark_we = 1'b1;
        mark_wa = clr_r;
        if (clr_r == NAW'(MAX_NODES)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + NAW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last_edge;
          if (edge_ok) begin
            edge_we   = 1'b1;
            edge_wa   = cnt_r[EIW-1:0];
            edge_wd   = {a_n, b_n};
            deg_ra0   = a_n;
            a_nxt     = a_n;
            b_nxt     = b_n;
            cnt_nxt   = cnt_r + EAW'(1);
            state_nxt = S_INC_A;
          end else begin
            drop_nxt = 1'b1;
            if (in_last_edge) begin
              k_nxt     = '0;
              u_nxt     = NAW'(1);
              state_nxt = (cnt_r == '0) ? S_U_HEAD : S_O_EDGE;
            end
          end
        end
      end
      // degree of first end
      S_INC_A: begin
        deg_we    = 1'b1;
        deg_wa    = a_r;
        deg_wd    = deg_rd0 + DW'(1);
        inc_nxt   = deg_rd0 + DW'(1);
        deg_ra0   = b_r;
        state_nxt = S_INC_B;
      end
      // degree of second end, forwarded on a self-loop
      S_INC_B: begin
        b_deg  = (b_r == a_r) ? inc_r : deg_rd0;
        deg_we = 1'b1;
        deg_wa = b_r;
        deg_wd = b_deg + DW'(1);
        if (last_r) begin
          k_nxt     = '0;
          u_nxt     = NAW'(1);
          state_nxt = S_O_EDGE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_O_EDGE: begin
        edge_ra   = k_r[EIW-1:0];
        state_nxt = S_O_DEG;
      end
      S_O_DEG: begin
        ea_nxt    = edge_rd[2*NAW-1:NAW];
        eb_nxt    = edge_rd[NAW-1:0];
        deg_ra0   = edge_rd[2*NAW-1:NAW];
        deg_ra1   = edge_rd[NAW-1:0];
        state_nxt = S_O_HEAD;
      end
      // orient toward the higher degree, ties toward the higher id
      S_O_HEAD: begin
        if ((deg_rd0 < deg_rd1) || ((deg_rd0 == deg_rd1) && (ea_r < eb_r))) begin
          src_nxt = ea_r;
          dst_nxt = eb_r;
          head_ra = ea_r;
        end else begin
          src_nxt = eb_r;
          dst_nxt = ea_r;
          head_ra = eb_r;
        end
        state_nxt = S_O_LINK;
      end
      // push onto the source list
      S_O_LINK: begin
        list_we = 1'b1;
        list_wa = slot;
        list_wd = {dst_r, head_rd};
        head_we = 1'b1;
        head_wa = src_r;
        head_wd = slot;
        k_nxt   = slot;
        state_nxt = (slot == cnt_r) ? S_U_HEAD : S_O_EDGE;
      end
      S_U_HEAD: begin
        head_ra   = u_r;
        state_nxt = S_U_FIRST;
      end
      S_U_FIRST: begin
        hu_nxt = head_rd;
        if (head_rd == '0) begin
          adv_u = 1'b1;
        end else begin
          list_ra   = head_rd;
          state_nxt = S_M_WALK;
        end
      end
      // mark out-neighbors of u
      S_M_WALK: begin
        mark_we = 1'b1;
        mark_wa = list_rd[LW-1:EAW];
        mark_wd = u_r;
        if (list_rd[EAW-1:0] != '0) begin
          list_ra = list_rd[EAW-1:0];
        end else begin
          list_ra   = hu_r;
          state_nxt = S_P_LIST;
        end
      end
      S_P_LIST: begin
        p_nxt     = list_rd[EAW-1:0];
        head_ra   = list_rd[LW-1:EAW];
        state_nxt = S_Q_HEAD;
      end
      S_Q_HEAD: begin
        if (head_rd == '0) begin
          adv_p = 1'b1;
        end else begin
          list_ra   = head_rd;
          state_nxt = S_Q_LIST;
        end
      end
      S_Q_LIST: begin
        q_nxt     = list_rd[EAW-1:0];
        mark_ra   = list_rd[LW-1:EAW];
        state_nxt = S_Q_MARK;
      end
      // two-hop path closes a triangle
      S_Q_MARK: begin
        if ((mark_rd == u_r) && (tri_r != TRI_MAX)) begin
          tri_nxt = tri_r + TRI_W'(1);
        end
        if (q_r != '0) begin
          list_ra   = q_r;
          state_nxt = S_Q_LIST;
        end else begin
          adv_p = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_tri_nxt   = tri_r;
          out_edges_nxt = EDGE_OUT_W'(cnt_r);
          out_ovf_nxt   = drop_r;
          cnt_nxt       = '0;
          tri_nxt       = '0;
          drop_nxt      = 1'b0;
          clr_nxt       = '0;
          state_nxt     = S_CLR;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase

    // next out-neighbor of u
    if (adv_p) begin
      if (p_r == '0) begin
        adv_u = 1'b1;
      end else begin
        list_ra   = p_r;
        state_nxt = S_P_LIST;
      end
    end

    // next vertex
    if (adv_u) begin
      if (u_r == NAW'(MAX_NODES)) begin
        state_nxt = S_DONE;
      end else begin
        u_nxt     = u_r + NAW'(1);
        state_nxt = S_U_HEAD;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    inc_r       <= inc_nxt;
    k_r         <= k_nxt;
    ea_r        <= ea_nxt;
    eb_r        <= eb_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    u_r         <= u_nxt;
    hu_r        <= hu_nxt;
    p_r         <= p_nxt;
    q_r         <= q_nxt;
    out_tri_r   <= out_tri_nxt;
    out_edges_r <= out_edges_nxt;
    out_ovf_r   <= out_ovf_nxt;
    if (!rst_n) begin
      state_r      <= S_CLR;
      node_count_r <= NODE_COUNT_RESET;
      cnt_r        <= '0;
      drop_r       <= 1'b0;
      tri_r        <= '0;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      cnt_r        <= cnt_nxt;
      drop_r       <= drop_nxt;
      tri_r        <= tri_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_triangle_count = out_tri_r;
  assign out_edges_loaded   = out_edges_r;
  assign out_overflow       = out_ovf_r;

endmodule

// ----- test/triangle_count_oriented_unit_tb.sv -----
module triangle_count_oriented_unit_tb;
  import tcnt_pkg::*;

  localparam int NODES_CAP = 4096;
  localparam int EDGES_CAP = 8192;
  localparam int HOLD_CYCLES = 40000;

  // idling modes
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    logic            last;
  } edge_req_t;

  typedef struct {
    logic [TRI_W-1:0]      tri_cnt;
    logic [EDGE_OUT_W-1:0] edges;
    logic                  ovf;
  } graph_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ID_W-1:0]       in_end_a = '0;
  logic [ID_W-1:0]       in_end_b = '0;
  logic                  in_last_edge = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TRI_W-1:0]      out_triangle_count;
  logic [EDGE_OUT_W-1:0] out_edges_loaded;
  logic                  out_overflow;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [ID_W-1:0]       cfg_node_count = '0;

  triangle_count_oriented_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_end_a(in_end_a), .in_end_b(in_end_b), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_triangle_count(out_triangle_count), .out_edges_loaded(out_edges_loaded),
    .out_overflow(out_overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_node_count(cfg_node_count)
  );

  edge_req_t     pend_edges[$];
  graph_result_t want_results[$];
  idle_mode_t    idle_mode = IDLE_NONE;
  int            errors = 0;
  logic          in_took = 1'b0;
  int            hold_asked = 0;
  int            hold_served = 0;
  int            hold_left = 0;

  // predictor state
  logic [ID_W-1:0] node_cnt_q = NODE_COUNT_RESET;
  int deg[NODES_CAP+1];
  int end_first[$];
  int end_second[$];
  int stored_cnt = 0;
  bit dropped = 0;
  int head_of[NODES_CAP+1];
  int slot_dst[EDGES_CAP+1];
  int slot_nxt[EDGES_CAP+1];
  int mark_of[NODES_CAP+1];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(input string what, input int got, input int exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  // orient, build lists and count two-hop paths closing on a marked vertex
  function automatic graph_result_t count_graph();
    graph_result_t r;
    int src, dst, a, b, u, p, q, v, slot, total;
    slot = 0;
    total = 0;
    for (int i = 0; i <= NODES_CAP; i++) begin
      head_of[i] = 0;
      mark_of[i] = 0;
    end
    for (int k = 0; k < stored_cnt; k++) begin
      a = end_first[k];
      b = end_second[k];
      if (deg[a] < deg[b] || (deg[a] == deg[b] && a < b)) begin
        src = a; dst = b;
      end else begin
        src = b; dst = a;
      end
      slot++;
      slot_dst[slot] = dst;
      slot_nxt[slot] = head_of[src];
      head_of[src] = slot;
    end
    for (u = 1; u <= NODES_CAP; u++) begin
      for (p = head_of[u]; p != 0; p = slot_nxt[p]) mark_of[slot_dst[p]] = u;
      for (p = head_of[u]; p != 0; p = slot_nxt[p]) begin
        v = slot_dst[p];
        for (q = head_of[v]; q != 0; q = slot_nxt[q])
          if (mark_of[slot_dst[q]] == u && total < int'(TRI_MAX)) total++;
      end
    end
    r.tri_cnt = TRI_W'(total);
    r.edges = EDGE_OUT_W'(stored_cnt);
    r.ovf = dropped;
    return r;
  endfunction

  // update the prediction for one accepted edge request
  task automatic predict_edge(input edge_req_t e);
    int lim;
    lim = (int'(node_cnt_q) > NODES_CAP) ? NODES_CAP : int'(node_cnt_q);
    if (e.a == 0 || e.b == 0 || e.a > lim || e.b > lim || stored_cnt >= EDGES_CAP) begin
      dropped = 1;
    end else begin
      end_first.push_back(int'(e.a));
      end_second.push_back(int'(e.b));
      stored_cnt++;
      deg[e.a]++;
      deg[e.b]++;
    end
    if (e.last) begin
      want_results.push_back(count_graph());
      for (int i = 0; i <= NODES_CAP; i++) deg[i] = 0;
      end_first.delete();
      end_second.delete();
      stored_cnt = 0;
      dropped = 0;
    end
  endtask

  // sample accepted requests and results
  always @(posedge clk) begin
    edge_req_t e;
    graph_result_t w;
    in_took <= in_valid && !in_stall && rst_n;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) node_cnt_q = cfg_node_count;
      if (in_valid && !in_stall) begin
        e.a = in_end_a;
        e.b = in_end_b;
        e.last = in_last_edge;
        predict_edge(e);
      end
      if (out_valid && !out_stall) begin
        if (want_results.size() == 0) begin
          report("unexpected result", int'(out_triangle_count), 0);
        end else begin
          w = want_results.pop_front();
          if (out_triangle_count !== w.tri_cnt)
            report("triangle_count", int'(out_triangle_count), int'(w.tri_cnt));
          if (out_edges_loaded !== w.edges)
            report("edges_loaded", int'(out_edges_loaded), int'(w.edges));
          if (out_overflow !== w.ovf) report("overflow", int'(out_overflow), int'(w.ovf));
        end
      end
    end
  end

  // edge request driver
  always @(negedge clk) begin
    edge_req_t e;
    bit idle;
    idle = (idle_mode == IDLE_SEND && $urandom_range(99) < 57) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 6);
    if (!in_valid || in_took) begin
      if (rst_n && pend_edges.size() > 0 && !idle) begin
        e = pend_edges.pop_front();
        in_valid <= 1'b1;
        in_end_a <= e.a;
        in_end_b <= e.b;
        in_last_edge <= e.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (idle_mode == IDLE_RECV && $urandom_range(99) < 57) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(99) < 6);
    end
  end

  task automatic add_edge(input int a, input int b, input bit last);
    edge_req_t e;
    e.a = ID_W'(a);
    e.b = ID_W'(b);
    e.last = last;
    pend_edges.push_back(e);
  endtask

  task automatic write_node_count(input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_node_count <= ID_W'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pend_edges.size() > 0 || in_valid || want_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // mostly legal ids, some zero, out of range or fully random
  function automatic int pick_id(input int lim);
    int r;
    r = $urandom_range(99);
    if (r < 84) return int'($urandom_range(lim, 1));
    if (r < 90) return 0;
    if (r < 95) return lim + 1 + int'($urandom_range(3));
    return int'($urandom() & 32'h1fff);
  endfunction

  initial begin
    int nc_pick[7] = '{3, 5, 8, 12, 20, 4096, 8191};
    int nc, lim, n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: triangle, self-loop, high ids, bad ids, repeated last edge
    write_node_count(8191);
    add_edge(1, 2, 0);
    add_edge(2, 3, 0);
    add_edge(3, 1, 0);
    add_edge(4096, 4096, 0);
    add_edge(8191, 1, 0);
    add_edge(1, 8191, 0);
    add_edge(0, 5, 0);
    add_edge(4097, 1, 0);
    add_edge(4095, 4096, 0);
    add_edge(1, 2, 1);
    wait_drained();
    // zero node count drops all, dropped last still closes the graph
    write_node_count(0);
    add_edge(1, 1, 1);
    wait_drained();
    write_node_count(1);
    add_edge(1, 1, 0);
    add_edge(1, 2, 0);
    add_edge(1, 1, 1);
    wait_drained();
    write_node_count(4);
    add_edge(1, 2, 0);
    add_edge(2, 3, 0);
    add_edge(3, 4, 0);
    add_edge(4, 1, 0);
    add_edge(1, 3, 0);
    add_edge(2, 4, 1);
    wait_drained();

    // random graphs across idling modes
    for (int ph = 0; ph < 9; ph++) begin
      nc = nc_pick[$urandom_range(6)];
      if (ph == 0) nc = 8;
      write_node_count(nc);
      lim = (nc > NODES_CAP) ? NODES_CAP : nc;
      idle_mode = idle_mode_t'(ph % 4);
      if (ph == 4) hold_asked++;
      for (int g = 0; g < 4; g++) begin
        n = $urandom_range(35, 5);
        for (int i = 0; i < n; i++) add_edge(pick_id(lim), pick_id(lim), i == n - 1);
      end
      wait_drained();
    end

    idle_mode = IDLE_NONE;
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/tcnt_pkg.sv
design/tcnt_ram.sv
design/tcnt_ram2r.sv
design/triangle_count_oriented_unit.sv
test/triangle_count_oriented_unit_tb.sv
